// ===== rtl/jts_pkg.sv =====
// ----------------------------------------------------------------------------
// jts_pkg
// shared types, byte codes and helper functions for the json token scanner
// ----------------------------------------------------------------------------
package jts_pkg;

    // lexeme length limit and the width of a saturating length
    localparam int MAX_LEXEME = 64;
    localparam int LEN_W      = $clog2(MAX_LEXEME + 1);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LEXEME);

    // result queue sizing
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // stream widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    // scanner mode
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_STRING = 3'd1,
        MODE_WORD   = 3'd2,
        MODE_NUMBER = 3'd3,
        MODE_SKIP   = 3'd4
    } t_mode;

    // token kinds
    typedef enum logic [3:0] {
        K_SPACE    = 4'd0,
        K_TAB      = 4'd1,
        K_NEWLINE  = 4'd2,
        K_STRING   = 4'd3,
        K_LBRACE   = 4'd4,
        K_RBRACE   = 4'd5,
        K_LBRACKET = 4'd6,
        K_RBRACKET = 4'd7,
        K_COLON    = 4'd8,
        K_COMMA    = 4'd9,
        K_FALSE    = 4'd10,
        K_TRUE     = 4'd11,
        K_NULL     = 4'd12,
        K_NUMBER   = 4'd13,
        K_ERROR    = 4'd14,
        K_END      = 4'd15
    } t_kind;

    // number phases
    localparam logic [2:0] NUM_INT   = 3'd0;
    localparam logic [2:0] NUM_POINT = 3'd1;
    localparam logic [2:0] NUM_FRAC  = 3'd2;
    localparam logic [2:0] NUM_EXP   = 3'd3;
    localparam logic [2:0] NUM_SIGN  = 3'd4;
    localparam logic [2:0] NUM_EXPD  = 3'd5;

    // literal selectors
    localparam logic [1:0] LIT_FALSE = 2'd0;
    localparam logic [1:0] LIT_TRUE  = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    // byte codes
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_UP_E     = 8'h45;
    localparam logic [7:0] CH_UP_F     = 8'h46;
    localparam logic [7:0] CH_UP_N     = 8'h4E;
    localparam logic [7:0] CH_UP_T     = 8'h54;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LO_A     = 8'h61;
    localparam logic [7:0] CH_LO_E     = 8'h65;
    localparam logic [7:0] CH_LO_F     = 8'h66;
    localparam logic [7:0] CH_LO_L     = 8'h6C;
    localparam logic [7:0] CH_LO_N     = 8'h6E;
    localparam logic [7:0] CH_LO_R     = 8'h72;
    localparam logic [7:0] CH_LO_S     = 8'h73;
    localparam logic [7:0] CH_LO_T     = 8'h74;
    localparam logic [7:0] CH_LO_U     = 8'h75;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CASE_BIT    = 8'h20;

    // scanner state
    typedef struct packed {
        t_mode            mode;
        logic [2:0]       sub;
        logic [1:0]       lit;
        logic             uc;
        logic [LEN_W-1:0] len;
    } t_scan_state;

    // one result token
    typedef struct packed {
        t_kind            kind;
        logic [LEN_W-1:0] len;
        logic             last;
    } t_token;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [LEN_W-1:0] grow(input logic [LEN_W-1:0] len);
        return (len < MAX_LEN) ? LEN_W'(len + 1'b1) : len;
    endfunction

    // lower-case letter of a literal at a position
    function automatic logic [7:0] word_char(input logic [1:0] lk, input logic [2:0] idx);
        logic [7:0] c;
        case ({lk, idx})
            {LIT_FALSE, 3'd0}: c = CH_LO_F;
            {LIT_FALSE, 3'd1}: c = CH_LO_A;
            {LIT_FALSE, 3'd2}: c = CH_LO_L;
            {LIT_FALSE, 3'd3}: c = CH_LO_S;
            {LIT_FALSE, 3'd4}: c = CH_LO_E;
            {LIT_TRUE, 3'd0}:  c = CH_LO_T;
            {LIT_TRUE, 3'd1}:  c = CH_LO_R;
            {LIT_TRUE, 3'd2}:  c = CH_LO_U;
            {LIT_TRUE, 3'd3}:  c = CH_LO_E;
            {LIT_NULL, 3'd0}:  c = CH_LO_N;
            {LIT_NULL, 3'd1}:  c = CH_LO_U;
            {LIT_NULL, 3'd2}:  c = CH_LO_L;
            {LIT_NULL, 3'd3}:  c = CH_LO_L;
            default:           c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] word_len(input logic [1:0] lk);
        return (lk == LIT_FALSE) ? 3'd5 : 3'd4;
    endfunction

endpackage

// ===== rtl/jts_step.sv =====
// ----------------------------------------------------------------------------
// jts_step
// one scanning step: next scanner state and up to two tokens for one beat
// ----------------------------------------------------------------------------
module jts_step (
    input  jts_pkg::t_scan_state i_state,
    input  logic [7:0]           i_ch,
    input  logic                 i_end_of_input,
    output jts_pkg::t_scan_state o_next,
    output logic [1:0]           o_count,
    output jts_pkg::t_token      o_tok0,
    output jts_pkg::t_token      o_tok1
);
    import jts_pkg::*;

    // byte classes
    logic       c_lf;
    logic       c_digit;
    logic       c_single;
    logic       c_letter;
    logic       c_word_delim;
    logic       c_num_delim;
    logic       c_str_break;
    t_kind      c_single_kind;

    // word decode
    logic [1:0] w_lk;
    logic [7:0] w_want;
    logic       w_in;
    logic       w_match;
    t_kind      w_kind;

    // number decode
    logic       n_adv;
    logic [2:0] n_sub;
    logic       n_fin;

    // idle-mode handling of a byte, used directly and after a delimiter
    function automatic t_scan_state start_next(input t_scan_state s, input logic [7:0] c);
        t_scan_state r;
        r      = s;
        r.mode = MODE_IDLE;
        r.sub  = 3'd0;
        r.len  = LEN_W'(1);
        if (c == CH_QUOTE) begin
            r.mode = MODE_STRING;
        end else if (c == CH_LO_F || c == CH_UP_F || c == CH_LO_T || c == CH_UP_T ||
                     c == CH_LO_N || c == CH_UP_N) begin
            r.lit  = (c == CH_LO_F || c == CH_UP_F) ? LIT_FALSE :
                     ((c == CH_LO_T || c == CH_UP_T) ? LIT_TRUE : LIT_NULL);
            r.uc   = (c < CH_LO_A);
            r.sub  = 3'd1;
            r.mode = MODE_WORD;
        end else if (is_digit(c)) begin
            r.mode = MODE_NUMBER;
        end else if (!c_single) begin
            r.mode = MODE_SKIP;
        end
        return r;
    endfunction

    // byte classification
    always_comb begin
        c_lf         = (i_ch == CH_LF);
        c_digit      = is_digit(i_ch);
        c_letter     = (i_ch == CH_LO_F || i_ch == CH_UP_F || i_ch == CH_LO_T ||
                        i_ch == CH_UP_T || i_ch == CH_LO_N || i_ch == CH_UP_N);
        c_word_delim = (i_ch == CH_SPACE || i_ch == CH_TAB || c_lf ||
                        i_ch == CH_COMMA || i_ch == CH_COLON);
        c_num_delim  = (i_ch == CH_SPACE || i_ch == CH_TAB || c_lf || i_ch == CH_COMMA);
        c_str_break  = (i_ch == CH_COMMA || c_lf || i_ch == CH_COLON);
        c_single     = 1'b1;
        case (i_ch)
            CH_SPACE:    c_single_kind = K_SPACE;
            CH_TAB:      c_single_kind = K_TAB;
            CH_LF:       c_single_kind = K_NEWLINE;
            CH_LBRACE:   c_single_kind = K_LBRACE;
            CH_RBRACE:   c_single_kind = K_RBRACE;
            CH_LBRACKET: c_single_kind = K_LBRACKET;
            CH_RBRACKET: c_single_kind = K_RBRACKET;
            CH_COLON:    c_single_kind = K_COLON;
            CH_COMMA:    c_single_kind = K_COMMA;
            default: begin
                c_single_kind = K_ERROR;
                c_single      = 1'b0;
            end
        endcase
    end

    // word and number decode of the pending token
    always_comb begin
        w_lk    = (i_state.lit > LIT_NULL) ? LIT_NULL : i_state.lit;
        w_want  = word_char(w_lk, i_state.sub) ^ (i_state.uc ? CASE_BIT : 8'h00);
        w_in    = (i_state.sub < word_len(w_lk));
        w_match = (i_ch == w_want);
        case (w_lk)
            LIT_FALSE: w_kind = K_FALSE;
            LIT_TRUE:  w_kind = K_TRUE;
            default:   w_kind = K_NULL;
        endcase

        n_adv = 1'b1;
        n_sub = i_state.sub;
        n_fin = 1'b0;
        if ((i_state.sub == NUM_INT || i_state.sub == NUM_FRAC ||
             i_state.sub == NUM_EXPD) && c_digit) begin
            n_sub = i_state.sub;
        end else if (i_state.sub == NUM_INT && i_ch == CH_DOT) begin
            n_sub = NUM_POINT;
        end else if ((i_state.sub == NUM_INT || i_state.sub == NUM_FRAC) &&
                     (i_ch == CH_LO_E || i_ch == CH_UP_E)) begin
            n_sub = NUM_EXP;
        end else if (i_state.sub == NUM_POINT && c_digit) begin
            n_sub = NUM_FRAC;
        end else if (i_state.sub == NUM_EXP && (i_ch == CH_PLUS || i_ch == CH_MINUS)) begin
            n_sub = NUM_SIGN;
        end else if ((i_state.sub == NUM_EXP || i_state.sub == NUM_SIGN) && c_digit) begin
            n_sub = NUM_EXPD;
        end else begin
            n_adv = 1'b0;
            n_fin = (i_state.sub == NUM_INT || i_state.sub == NUM_FRAC ||
                     i_state.sub == NUM_EXPD) && c_num_delim;
        end
    end

    // next state
    always_comb begin
        o_next = i_state;
        if (i_end_of_input) begin
            o_next.mode = MODE_IDLE;
            o_next.sub  = 3'd0;
            o_next.lit  = LIT_FALSE;
            o_next.uc   = 1'b0;
            o_next.len  = '0;
        end else begin
            case (i_state.mode)
                MODE_STRING: begin
                    o_next.len = grow(i_state.len);
                    if (i_ch == CH_QUOTE) begin
                        o_next.mode = MODE_IDLE;
                    end else if (c_str_break) begin
                        o_next.mode = c_lf ? MODE_IDLE : MODE_SKIP;
                    end
                end
                MODE_WORD: begin
                    if (w_in && w_match) begin
                        o_next.sub = i_state.sub + 3'd1;
                        o_next.len = grow(i_state.len);
                    end else if (!w_in && c_word_delim) begin
                        o_next = start_next(i_state, i_ch);
                    end else begin
                        o_next.mode = c_lf ? MODE_IDLE : MODE_SKIP;
                    end
                end
                MODE_NUMBER: begin
                    if (n_adv) begin
                        o_next.sub = n_sub;
                        o_next.len = grow(i_state.len);
                    end else if (n_fin) begin
                        o_next = start_next(i_state, i_ch);
                    end else begin
                        o_next.mode = c_lf ? MODE_IDLE : MODE_SKIP;
                    end
                end
                MODE_SKIP: begin
                    if (c_lf) begin
                        o_next.mode = MODE_IDLE;
                    end
                end
                default: begin
                    o_next = start_next(i_state, i_ch);
                end
            endcase
        end
    end

    // result tokens
    always_comb begin
        o_count     = 2'd0;
        o_tok0.kind = K_ERROR;
        o_tok0.len  = '0;
        o_tok1.kind = K_NEWLINE;
        o_tok1.len  = LEN_W'(1);
        if (i_end_of_input) begin
            if (i_state.mode == MODE_STRING || i_state.mode == MODE_WORD ||
                i_state.mode == MODE_NUMBER) begin
                o_count     = 2'd2;
                o_tok1.kind = K_END;
                o_tok1.len  = '0;
            end else begin
                o_count     = 2'd1;
                o_tok0.kind = K_END;
            end
        end else begin
            case (i_state.mode)
                MODE_STRING: begin
                    if (i_ch == CH_QUOTE) begin
                        o_count     = 2'd1;
                        o_tok0.kind = K_STRING;
                        o_tok0.len  = grow(i_state.len);
                    end else if (c_str_break) begin
                        o_count = c_lf ? 2'd2 : 2'd1;
                    end
                end
                MODE_WORD: begin
                    if (w_in && w_match) begin
                        o_count = 2'd0;
                    end else if (!w_in && c_word_delim) begin
                        // delimiters are always single-byte tokens
                        o_count     = 2'd2;
                        o_tok0.kind = w_kind;
                        o_tok0.len  = i_state.len;
                        o_tok1.kind = c_single_kind;
                    end else begin
                        o_count = c_lf ? 2'd2 : 2'd1;
                    end
                end
                MODE_NUMBER: begin
                    if (n_adv) begin
                        o_count = 2'd0;
                    end else if (n_fin) begin
                        o_count     = 2'd2;
                        o_tok0.kind = K_NUMBER;
                        o_tok0.len  = i_state.len;
                        o_tok1.kind = c_single_kind;
                    end else begin
                        o_count = c_lf ? 2'd2 : 2'd1;
                    end
                end
                MODE_SKIP: begin
                    if (c_lf) begin
                        o_count     = 2'd1;
                        o_tok0.kind = K_NEWLINE;
                        o_tok0.len  = LEN_W'(1);
                    end
                end
                default: begin
                    // strings, words and numbers open silently
                    if (c_single) begin
                        o_count     = 2'd1;
                        o_tok0.kind = c_single_kind;
                        o_tok0.len  = LEN_W'(1);
                    end else if (!(i_ch == CH_QUOTE || c_letter || c_digit)) begin
                        o_count = 2'd1;
                    end
                end
            endcase
        end
        o_tok0.last = (o_count == 2'd1);
        o_tok1.last = 1'b1;
    end

endmodule

// ===== rtl/jts_out_fifo.sv =====
// ----------------------------------------------------------------------------
// jts_out_fifo
// small token queue that takes up to two tokens and gives one per cycle while the reader is ready
// ----------------------------------------------------------------------------
module jts_out_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_push_count,
    input  jts_pkg::t_token i_tok0,
    input  jts_pkg::t_token i_tok1,
    input  logic            i_ready,
    output logic            o_valid,
    output jts_pkg::t_token o_tok,
    output logic            o_room
);
    import jts_pkg::*;

    t_token               r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr;
    logic [OUT_PTR_W-1:0] r_rd;
    logic [OUT_CNT_W-1:0] r_count;
    logic [OUT_PTR_W-1:0] n_wr;
    logic [OUT_PTR_W-1:0] n_rd;
    logic [OUT_CNT_W-1:0] n_count;
    logic                 pop;

    // status and read side
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd];
    assign o_room  = (r_count <= OUT_CNT_W'(OUT_DEPTH - 2));
    assign pop     = o_valid && i_ready;

    // pointer and level update
    always_comb begin
        n_wr    = r_wr + OUT_PTR_W'(i_push_count);
        n_rd    = r_rd + OUT_PTR_W'(pop);
        n_count = r_count + OUT_CNT_W'(i_push_count) - OUT_CNT_W'(pop);
    end

    // token storage
    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr] <= i_tok0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[r_wr + OUT_PTR_W'(1)] <= i_tok1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/json_token_scanner_core.sv =====
// ----------------------------------------------------------------------------
// json_token_scanner_core
// json lexer: one source byte per beat in, tokens with kind and length out
// ----------------------------------------------------------------------------
// output: tokens of a beat are registered in the token queue and reach m_axis after any tokens queued before them
// throughput: one byte per cycle while the token queue has room; a beat that
//   yields two tokens leaves the queue one token at a time, and s_axis_tready
//   stays high while the 4-entry token queue has room for two tokens
// reset: synchronous, active low; scanner returns to idle, queue empties
// ----------------------------------------------------------------------------
module json_token_scanner_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [jts_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] ch
    input  logic                           s_axis_tuser,   // [0] end_of_input
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [jts_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [3:0] token_kind,
                                                           // [10:4] lexeme_length
    output logic                           m_axis_tlast    // last
);
    import jts_pkg::*;

    t_scan_state r_state;
    t_scan_state n_state;
    t_scan_state step_next;
    t_token      tok0;
    t_token      tok1;
    t_token      out_tok;
    logic [1:0]  step_count;
    logic [1:0]  push_count;
    logic        in_beat;
    logic        room;

    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = room;

    // scanning step on the incoming beat
    jts_step u_step (
        .i_state        (r_state),
        .i_ch           (s_axis_tdata),
        .i_end_of_input (s_axis_tuser),
        .o_next         (step_next),
        .o_count        (step_count),
        .o_tok0         (tok0),
        .o_tok1         (tok1)
    );

    assign push_count = in_beat ? step_count : 2'd0;
    assign n_state    = in_beat ? step_next : r_state;

    // scanner state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode <= MODE_IDLE;
            r_state.sub  <= 3'd0;
            r_state.lit  <= LIT_FALSE;
            r_state.uc   <= 1'b0;
            r_state.len  <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    // token queue toward the output
    jts_out_fifo u_out_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_tok0       (tok0),
        .i_tok1       (tok1),
        .i_ready      (m_axis_tready),
        .o_valid      (m_axis_tvalid),
        .o_tok        (out_tok),
        .o_room       (room)
    );

    assign m_axis_tdata = {(OUT_DATA_W - 4 - LEN_W)'(0), out_tok.len, out_tok.kind};
    assign m_axis_tlast = out_tok.last;

    // pending lexeme length never passes the limit
    a_len_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.len <= MAX_LEN)
        else $error("lexeme length above limit");

    // end of input always brings the scanner back to idle with no pending bytes
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && s_axis_tuser) |=> (r_state.mode == MODE_IDLE && r_state.len == '0))
        else $error("scanner not idle after end of input");

    // dropping continues until a newline arrives
    a_skip_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && !s_axis_tuser && r_state.mode == MODE_SKIP && s_axis_tdata != CH_LF)
        |=> (r_state.mode == MODE_SKIP))
        else $error("skip mode left without newline");

    // an empty output side never blocks the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty token queue");

endmodule
